/* rtl/core/pci_pkg.sv */
// Shared types and constants for the piecewise-constant integrator.
`default_nettype none

package pci_pkg;

	// Accumulator and product widths (times Q16.16 x values Q8.24 or Q16.48, scale 2^-64)
	localparam int ACC_W  = 108;
	localparam int PROD_W = 97;
	localparam int Q_MSB  = 95;
	localparam int Q_LSB  = 32;

	localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

	// Request opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               op;
		logic [5:0]         entry_index;
		logic [31:0]        pillar_time;
		logic signed [31:0] segment_value;
		logic [31:0]        start_time;
		logic [31:0]        end_time;
		logic               squared;
	} pci_req_t;

	typedef struct packed {
		logic signed [63:0] integral;
		logic               overflowed;
	} pci_res_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SCAN_S,
		ST_SCAN_E,
		ST_LAST
	} pci_state_t;

	// One segment term handed from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic               valid;
		logic               first;
		logic               last;
		logic signed [32:0] delta;
		logic signed [31:0] value;
		logic               squared;
	} pci_term_t;

endpackage

`default_nettype wire

/* rtl/core/pci_mac.sv */
// Pipelined multiply-accumulate unit: delta times value (or value squared) summed exactly.
`default_nettype none

module pci_mac (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pci_pkg::pci_term_t                  term,
	output logic                                     done,
	output logic signed [pci_pkg::ACC_W-1:0]         acc
);

	logic                               vld_s1, vld_s2, vld_s3, vld_s4;
	logic                               first_s1, first_s2, first_s3, first_s4;
	logic                               last_s1, last_s2, last_s3, last_s4;
	logic signed [32:0]                 delta_s1, delta_s2;
	logic signed [63:0]                 mult_s1;
	logic signed [65:0]                 plo_s2, plo_s3;
	logic signed [31:0]                 mhi_s2;
	logic signed [64:0]                 phi_s3;
	logic signed [pci_pkg::PROD_W-1:0]  prod_s4;
	logic signed [pci_pkg::ACC_W-1:0]   acc_q;
	logic                               done_q;

	// Advance valid bits and the completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= term.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done_q <= vld_s4 && last_s4;
		end
	end

	// Stage 1: form the multiplier operand, value squared or value aligned to 2^-48
	always_ff @(posedge clk) begin
		first_s1 <= term.first;
		last_s1  <= term.last;
		delta_s1 <= term.delta;
		if (term.squared) begin
			mult_s1 <= 64'(term.value) * 64'(term.value);
		end else begin
			mult_s1 <= 64'(term.value) <<< 24;
		end
	end

	// Stage 2: delta times the low half of the operand
	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		delta_s2 <= delta_s1;
		mhi_s2   <= mult_s1[63:32];
		plo_s2   <= 66'(delta_s1) * 66'($signed({1'b0, mult_s1[31:0]}));
	end

	// Stage 3: delta times the high half of the operand
	always_ff @(posedge clk) begin
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		plo_s3   <= plo_s2;
		phi_s3   <= 65'(delta_s2) * 65'(mhi_s2);
	end

	// Stage 4: merge the partial products
	always_ff @(posedge clk) begin
		first_s4 <= first_s3;
		last_s4  <= last_s3;
		prod_s4  <= {phi_s3, 32'b0} + pci_pkg::PROD_W'(plo_s3);
	end

	// Accumulate; restart on the first term of a query
	always_ff @(posedge clk) begin
		if (vld_s4) begin
			if (first_s4) begin
				acc_q <= pci_pkg::ACC_W'(prod_s4);
			end else begin
				acc_q <= acc_q + pci_pkg::ACC_W'(prod_s4);
			end
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

/* rtl/core/piecewise_constant_integral_top.sv */
// Top level of the piecewise-constant integrator: table memory, scan sequencer, result register.
//
//  Channel   Signals                        Direction  Moves
//  -------   -----------------------------  ---------  ------------------------------------
//  in        in_valid / in_ready / in_req   sink       load or query request
//  out       out_valid / out_ready / out_res source    integral result of a query
//  cfg       cfg_we / cfg_wdata             sink       pillar_count, written without wait
//
// A query holds the sequencer while the scan walks the table memory one entry per cycle,
// first to the start segment, then on to the end segment. The result appears after the
// scan ends, behind the four-stage multiplier pipeline and the accumulator.
// Reset clears control state and sets pillar_count to 1; the table is undefined until loaded.
// A held result does not block new requests; a query waits at its last term only while
// the previous result is still in flight or unclaimed.
`default_nettype none

module piecewise_constant_integral_top #(
	parameter int MAX_PILLARS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pci_pkg::pci_req_t in_req,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pci_pkg::pci_res_t      out_res,
	input  wire logic              cfg_we,
	input  wire logic [6:0]        cfg_wdata
);

	localparam int IW = $clog2(MAX_PILLARS);
	localparam int CW = $clog2(MAX_PILLARS + 1);

	pci_pkg::pci_state_t state_q, state_d;

	logic [6:0]                       cfg_q;
	logic [31:0]                      cfg_ext;
	logic [CW-1:0]                    n_new, n_q, i_q, nxt, nxt2;
	logic                             has_next, adv_s, adv_e;
	logic [31:0]                      t1_q, t2_q, cur_q;
	logic signed [31:0]               v_cur_q;
	logic                             first_q, sq_q;
	logic                             pend_q, out_free;
	logic                             in_acc, is_query, is_load;
	logic [63:0]                      tbl_mem [MAX_PILLARS];
	logic [63:0]                      rd_q;
	logic [IW-1:0]                    rd_addr;
	logic [31:0]                      rd_bp;
	logic signed [31:0]               rd_val;
	pci_pkg::pci_term_t               term_d;
	logic                             mac_done;
	logic signed [pci_pkg::ACC_W-1:0] mac_acc;
	logic [pci_pkg::ACC_W-1:pci_pkg::Q_MSB] acc_top;
	logic                             sat;
	logic                             out_valid_q;
	pci_pkg::pci_res_t                out_q;

	// Decode the request and the scan conditions
	assign in_acc   = in_valid && in_ready;
	assign is_query = in_req.op == pci_pkg::OP_QUERY;
	assign is_load  = in_req.op == pci_pkg::OP_LOAD;
	assign nxt      = i_q + CW'(1);
	assign nxt2     = i_q + CW'(2);
	assign has_next = nxt < n_q;
	assign rd_bp    = rd_q[63:32];
	assign rd_val   = rd_q[31:0];
	assign adv_s    = has_next && (rd_bp <= t1_q);
	assign adv_e    = has_next && (rd_bp <= t2_q);
	assign out_free = !out_valid_q && !pend_q;

	// Clamp the pillar count to 1..MAX_PILLARS
	always_comb begin
		cfg_ext = 32'(cfg_q);
		if (cfg_ext == 32'd0) begin
			n_new = CW'(1);
		end else if (cfg_ext > MAX_PILLARS) begin
			n_new = CW'(MAX_PILLARS);
		end else begin
			n_new = CW'(cfg_ext);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pci_pkg::ST_IDLE: begin
				if (in_acc && is_query) state_d = pci_pkg::ST_FIRST;
			end
			pci_pkg::ST_FIRST: state_d = pci_pkg::ST_SCAN_S;
			pci_pkg::ST_SCAN_S: begin
				if (!adv_s) state_d = pci_pkg::ST_SCAN_E;
			end
			pci_pkg::ST_SCAN_E: begin
				if (!adv_e) state_d = pci_pkg::ST_LAST;
			end
			pci_pkg::ST_LAST: begin
				if (out_free) state_d = pci_pkg::ST_IDLE;
			end
			default: state_d = pci_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory read address and segment terms
	always_comb begin
		in_ready       = 1'b0;
		rd_addr        = '0;
		term_d.valid   = 1'b0;
		term_d.first   = first_q;
		term_d.last    = 1'b0;
		term_d.delta   = 33'(rd_bp) - 33'(cur_q);
		term_d.value   = v_cur_q;
		term_d.squared = sq_q;
		unique case (state_q)
			pci_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			pci_pkg::ST_FIRST: begin
				rd_addr = nxt[IW-1:0];
			end
			pci_pkg::ST_SCAN_S: begin
				rd_addr = adv_s ? nxt2[IW-1:0] : nxt[IW-1:0];
			end
			pci_pkg::ST_SCAN_E: begin
				rd_addr      = adv_e ? nxt2[IW-1:0] : nxt[IW-1:0];
				term_d.valid = adv_e;
			end
			pci_pkg::ST_LAST: begin
				term_d.valid = out_free;
				term_d.last  = 1'b1;
				term_d.delta = 33'(t2_q) - 33'(cur_q);
			end
			default: ;
		endcase
	end

	// Table memory: breakpoint time over segment value, one read port
	always_ff @(posedge clk) begin
		if (in_acc && is_load && (32'(in_req.entry_index) < MAX_PILLARS)) begin
			tbl_mem[IW'(in_req.entry_index)] <= {in_req.pillar_time, in_req.segment_value};
		end
		rd_q <= tbl_mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pci_pkg::ST_IDLE;
			cfg_q       <= 7'd1;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cfg_q <= cfg_wdata;
			if (term_d.valid && term_d.last) begin
				pend_q <= 1'b1;
			end else if (mac_done) begin
				pend_q <= 1'b0;
			end
			if (mac_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan registers: limits, current segment and its left bound
	always_ff @(posedge clk) begin
		case (state_q)
			pci_pkg::ST_IDLE: begin
				if (in_acc) begin
					t1_q    <= in_req.start_time;
					t2_q    <= in_req.end_time;
					sq_q    <= in_req.squared;
					n_q     <= n_new;
					i_q     <= '0;
					cur_q   <= in_req.start_time;
					first_q <= 1'b1;
				end
			end
			pci_pkg::ST_FIRST: begin
				v_cur_q <= rd_val;
			end
			pci_pkg::ST_SCAN_S: begin
				if (adv_s) begin
					i_q     <= nxt;
					v_cur_q <= rd_val;
				end
			end
			pci_pkg::ST_SCAN_E: begin
				if (adv_e) begin
					i_q     <= nxt;
					v_cur_q <= rd_val;
					cur_q   <= rd_bp;
					first_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	pci_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.term   (term_d),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	// Floor to Q32.32 and saturate
	assign acc_top = mac_acc[pci_pkg::ACC_W-1:pci_pkg::Q_MSB];
	assign sat     = !((&acc_top) || !(|acc_top));

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (mac_done) begin
			out_q.overflowed <= sat;
			if (sat) begin
				out_q.integral <= mac_acc[pci_pkg::ACC_W-1] ? pci_pkg::SAT_MIN : pci_pkg::SAT_MAX;
			end else begin
				out_q.integral <= mac_acc[pci_pkg::Q_MSB:pci_pkg::Q_LSB];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// A result in flight and a held result never coexist
	a_pend_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && out_valid_q))
		else $error("result in flight while output register is full");

	// Accumulator completes only for an issued last term
	a_done_pend: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> pend_q)
		else $error("accumulator finished without a pending query");

	// Scan index stays inside the table in use
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pci_pkg::ST_SCAN_S || state_q == pci_pkg::ST_SCAN_E) |-> (i_q < n_q))
		else $error("scan index beyond pillar count");

	// Issuing the last term marks a result as pending
	a_last_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pci_pkg::ST_LAST && out_free) |=> pend_q)
		else $error("last term issued without pending mark");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the piecewise-constant integrator: table loads, queries, pillar_count.
`default_nettype none

module testbench;

	localparam int TABLE_DEPTH   = 64;
	localparam int IDLE_PCT      = 9;
	localparam int SETTLE_CYCLES = 100;
	localparam int ITEM_TARGET   = 2000;
	localparam longint LIMIT_CYCLES = 1000000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	pci_pkg::pci_req_t  in_req    = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	pci_pkg::pci_res_t  out_res;
	logic               cfg_we    = 1'b0;
	logic [6:0]         cfg_wdata = 7'd0;

	// Bench-side copy of the block state
	logic [31:0] tbl_time  [TABLE_DEPTH];
	logic [31:0] tbl_value [TABLE_DEPTH];
	logic [6:0]  pillar_setting = 7'd1;

	// Breakpoints as loaded by the stimulus, used to aim query times
	logic [31:0] gen_bp [TABLE_DEPTH];

	pci_pkg::pci_req_t pending_reqs [$];
	pci_pkg::pci_res_t integrals_due [$];
	pci_pkg::pci_res_t oldest_due;
	logic     in_fire_q;
	logic     calm = 1'b0;

	int     mismatch_count = 0;
	int     results_checked = 0;
	int     saturated_seen = 0;
	int     loads_sent = 0;
	int     queries_sent = 0;
	int     settings_count = 0;
	longint cycle_count = 0;

	piecewise_constant_integral_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Clamp the register to the number of breakpoints actually scanned
	function automatic int unsigned clamp_count(input logic [6:0] setting);
		if (setting == 7'd0)
			return 1;
		if (setting > TABLE_DEPTH)
			return TABLE_DEPTH;
		return 32'(setting);
	endfunction

	function automatic logic signed [127:0] time_diff(input logic [31:0] a, input logic [31:0] b);
		return $signed({96'b0, a}) - $signed({96'b0, b});
	endfunction

	// Area of one span at scale 2^-64: Q16.16 width times Q8.24 value or its square
	function automatic logic signed [127:0] span_area(input logic signed [127:0] width,
			input logic [31:0] vraw, input logic sq);
		logic signed [127:0] v;
		logic signed [127:0] height;
		v = 128'($signed(vraw));
		height = sq ? v * v : (v <<< 24);
		return width * height;
	endfunction

	// Integrate the table between the query limits, floor to Q32.32 and saturate
	function automatic pci_pkg::pci_res_t integrate_query(input pci_pkg::pci_req_t rq);
		int unsigned n;
		int unsigned s;
		int unsigned e;
		int unsigned k;
		logic signed [127:0] acc;
		logic signed [127:0] q;
		pci_pkg::pci_res_t r;
		n = clamp_count(pillar_setting);
		s = 0;
		while (s + 1 < n && tbl_time[s + 1] <= rq.start_time)
			s++;
		e = s;
		while (e + 1 < n && tbl_time[e + 1] <= rq.end_time)
			e++;
		acc = '0;
		for (k = s; k < e; k++)
			acc += span_area(time_diff(tbl_time[k + 1], tbl_time[k]), tbl_value[k], rq.squared);
		acc += span_area(time_diff(rq.end_time, tbl_time[e]), tbl_value[e], rq.squared);
		acc -= span_area(time_diff(rq.start_time, tbl_time[s]), tbl_value[s], rq.squared);
		q = acc >>> 32;
		r.overflowed = !((&q[127:63]) || !(|q[127:63]));
		r.integral = r.overflowed ? (acc[127] ? pci_pkg::SAT_MIN : pci_pkg::SAT_MAX) : q[63:0];
		return r;
	endfunction

	// Build requests; fields the operation ignores carry random bits
	function automatic pci_pkg::pci_req_t load_req(input logic [5:0] idx, input logic [31:0] t,
			input logic [31:0] v);
		pci_pkg::pci_req_t r;
		r.op = pci_pkg::OP_LOAD;
		r.entry_index = idx;
		r.pillar_time = t;
		r.segment_value = v;
		r.start_time = $urandom;
		r.end_time = $urandom;
		r.squared = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic pci_pkg::pci_req_t query_req(input logic [31:0] t1, input logic [31:0] t2,
			input logic sq);
		pci_pkg::pci_req_t r;
		r.op = pci_pkg::OP_QUERY;
		r.entry_index = 6'($urandom);
		r.pillar_time = $urandom;
		r.segment_value = $urandom;
		r.start_time = t1;
		r.end_time = t2;
		r.squared = sq;
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Aim query limits at breakpoints, around them, inside the table span or anywhere
	function automatic logic [31:0] pick_time(input int unsigned n);
		int unsigned j;
		j = $urandom_range(n - 1);
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3: return gen_bp[j];
			4: return gen_bp[j] + $urandom_range(8) - 4;
			5: return $urandom;
			default: return $urandom_range(gen_bp[n - 1], gen_bp[0]);
		endcase
	endfunction

	task automatic send(input pci_pkg::pci_req_t rq);
		pending_reqs.push_back(rq);
		if (rq.op == pci_pkg::OP_LOAD) begin
			gen_bp[rq.entry_index] = rq.pillar_time;
			loads_sent++;
		end else begin
			queries_sent++;
		end
	endtask

	// Hold until every request is taken and every result is back, then let the block settle
	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || integrals_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pillar_count(input logic [6:0] setting);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= setting;
		@(negedge clk);
		cfg_we <= 1'b0;
		pillar_setting = setting;
		settings_count++;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Register acceptance so the driver knows at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_fire_q <= 1'b0;
		else
			in_fire_q <= in_valid && in_ready;
	end

	// Drive requests at the falling edge; hold the payload until it is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire_q) begin
			if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				in_req <= pending_reqs.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
	end

	// Predict on accepted requests and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (in_req.op == pci_pkg::OP_QUERY) begin
					integrals_due.push_back(integrate_query(in_req));
				end else begin
					tbl_time[in_req.entry_index] = in_req.pillar_time;
					tbl_value[in_req.entry_index] = in_req.segment_value;
				end
			end
			if (out_valid && out_ready) begin
				if (integrals_due.size() == 0) begin
					report_mismatch($sformatf("result %h with no query outstanding",
						out_res.integral));
				end else begin
					oldest_due = integrals_due.pop_front();
					results_checked++;
					if (oldest_due.overflowed)
						saturated_seen++;
					if (out_res.integral !== oldest_due.integral)
						report_mismatch($sformatf("integral got %h want %h",
							out_res.integral, oldest_due.integral));
					if (out_res.overflowed !== oldest_due.overflowed)
						report_mismatch($sformatf("overflowed got %b want %b",
							out_res.overflowed, oldest_due.overflowed));
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("piecewise_constant_integral_top: mismatch");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		int unsigned i;
		int unsigned phase;
		int unsigned step_max;
		int unsigned random_items;
		longint unsigned cursor;
		longint unsigned gap;
		logic [6:0] setting;
		logic ordered;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset value of pillar_count: only entry 0 is in use
		send(load_req(6'd0, 32'h0001_0000, 32'h7FFF_FFFF));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
		send(query_req(32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
		send(query_req(32'h0000_5555, 32'h0000_5555, 1'b1));
		send(load_req(6'd0, 32'hFFFF_FFFF, 32'h8000_0000));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
		drain();

		// Zero count behaves as one
		write_pillar_count(7'd0);
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
		send(query_req(32'h8000_0000, 32'h0000_1000, 1'b1));

		// Fill the whole table in ascending order before wider counts read it
		for (i = 0; i < TABLE_DEPTH; i++)
			send(load_req(i[5:0], i * 32'h0400_0000 + 32'h0001_0000, pick_value()));
		drain();

		// Count above the table depth saturates to the full table
		write_pillar_count(7'd127);
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
		send(query_req(32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
		send(query_req(gen_bp[10], gen_bp[20], 1'b0));
		send(query_req(gen_bp[63], 32'hFFFF_FFFF, 1'b1));
		drain();

		// Unordered breakpoints driving the squared sum to both saturation limits
		write_pillar_count(7'd7);
		for (i = 0; i < 7; i++)
			send(load_req(i[5:0], i[0] ? 32'hFFFF_FFFF : 32'h0000_0000,
				i[0] ? 32'h0000_0000 : 32'h8000_0000));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
		for (i = 0; i < 7; i++)
			send(load_req(i[5:0], i[0] ? 32'hFFFF_FFFF : 32'h0000_0000,
				i[0] ? 32'h8000_0000 : 32'h0000_0000));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
		send(query_req(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));

		// Random phases: new count, fresh table, then a burst of queries with some stray loads
		random_items = 0;
		phase = 0;
		while (random_items < ITEM_TARGET) begin
			drain();
			case ($urandom_range(9))
				0: setting = 7'd1;
				1: setting = 7'd64;
				2: setting = 7'($urandom_range(127, 65));
				3: setting = 7'd0;
				4, 5, 6: setting = 7'($urandom_range(8, 2));
				default: setting = 7'($urandom_range(64, 1));
			endcase
			write_pillar_count(setting);
			calm = (phase == 3);
			n = clamp_count(setting);
			ordered = ($urandom_range(9) != 0);
			gap = (($urandom_range(3) == 0) ? 64'h0010_0000 : 64'h1_0000_0000) / (n + 1);
			step_max = 32'(2 * gap - 1);
			cursor = 64'($urandom_range(32'(gap)));
			for (i = 0; i < n; i++) begin
				if (ordered) begin
					send(load_req(i[5:0], cursor > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : cursor[31:0],
						pick_value()));
					// Equal neighbors now and then
					if ($urandom_range(15) != 0)
						cursor += 64'($urandom_range(step_max, 1));
				end else begin
					send(load_req(i[5:0], $urandom, pick_value()));
				end
				random_items++;
			end
			repeat ($urandom_range(90, 40)) begin
				if ($urandom_range(9) == 0)
					send(load_req(6'($urandom), $urandom, pick_value()));
				else
					send(query_req(pick_time(n), pick_time(n), 1'($urandom_range(1))));
				random_items++;
			end
			phase++;
		end
		drain();
		calm = 1'b0;

		$display("Covered %0d loads and %0d queries over %0d pillar_count writes.",
			loads_sent, queries_sent, settings_count);
		$display("Checked %0d results, %0d of them saturated; %0d mismatches.",
			results_checked, saturated_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("piecewise_constant_integral_top: match");
		else
			$display("piecewise_constant_integral_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/pci_pkg.sv
rtl/core/pci_mac.sv
rtl/core/piecewise_constant_integral_top.sv
bench/testbench.sv
